>>> sv/bls_pkg.sv
// Package with widths, codes and types shared by the bounded LIFO stack.
`timescale 1ns / 1ps
`default_nettype none
package bls_pkg;

    localparam int DEFAULT_DEPTH = 64;
    localparam int CAP_W         = 7;
    localparam int VAL_W         = 32;
    localparam int ACT_W         = 2;
    localparam int ST_W          = 2;

    typedef logic [ACT_W-1:0] t_action;
    typedef logic [ST_W-1:0]  t_status;

    localparam t_action ACT_PUSH = 2'd0;
    localparam t_action ACT_POP  = 2'd1;
    localparam t_action ACT_PEEK = 2'd2;
    localparam t_action ACT_DUMP = 2'd3;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_OVERFLOW = 2'd1;
    localparam t_status ST_EMPTY    = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

endpackage
`default_nettype wire

>>> sv/bounded_lifo_stack_unit.sv
// Top level of the bounded LIFO stack of signed 32-bit words.
`timescale 1ns / 1ps
`default_nettype none
// Every result appears on the o_ ports in the cycle after its item is taken
// and is marked by o_valid for exactly one cycle; the receiver cannot stall.
// Push, pop and peek never raise busy, so such items can be started in
// every cycle while busy is low. A dump of N stored words gives N results
// back to back, one read of the entry memory per cycle, and holds busy high
// while its remaining reads are issued; a dump of an empty stack gives one
// result and leaves busy low. The entry memory needs no clearing after reset.
module bounded_lifo_stack_unit #(
    parameter int DEPTH = bls_pkg::DEFAULT_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_cfg_we,
    input  wire logic [bls_pkg::CAP_W-1:0]   i_cfg_wdata,
    input  wire logic [bls_pkg::ACT_W-1:0]   i_action,
    input  wire logic signed [bls_pkg::VAL_W-1:0] i_push_value,
    output logic                             o_valid,
    output logic signed [bls_pkg::VAL_W-1:0] o_result_value,
    output logic [bls_pkg::ST_W-1:0]         o_status,
    output logic                             o_last
);
    import bls_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CAP_W-1:0] DEPTH_CAP = CAP_W'(DEPTH);

    logic [CAP_W-1:0] r_cap;
    logic [CW-1:0]    r_count, n_count;
    logic             r_dumping, n_dumping;
    logic [AW-1:0]    r_dump_addr, n_dump_addr;
    logic             r_out_valid, n_out_valid;
    logic             r_out_from_ram, n_out_from_ram;
    t_status          r_out_status, n_out_status;
    logic             r_out_last, n_out_last;

    logic [CAP_W-1:0] cap_eff;
    logic [CAP_W-1:0] count_ext;
    logic             full;
    logic             empty;
    logic             accept;
    logic [CW-1:0]    count_m1;
    logic [CW-1:0]    count_m2;
    logic             ram_we;
    logic [AW-1:0]    ram_raddr;
    logic [VAL_W-1:0] ram_rdata;
    t_action          action;

    assign action    = i_action;
    assign cap_eff   = (r_cap > DEPTH_CAP) ? DEPTH_CAP : r_cap;
    assign count_ext = CAP_W'(r_count);
    assign full      = (count_ext >= cap_eff);
    assign empty     = (r_count == '0);
    assign busy      = r_dumping;
    assign accept    = start && !r_dumping;
    assign count_m1  = r_count - CW'(1);
    assign count_m2  = r_count - CW'(2);
    assign ram_we    = accept && (action == ACT_PUSH) && !full;
    assign ram_raddr = r_dumping ? r_dump_addr : count_m1[AW-1:0];

    bls_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (VAL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_push_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_count        = r_count;
        n_dumping      = r_dumping;
        n_dump_addr    = r_dump_addr;
        n_out_valid    = 1'b0;
        n_out_from_ram = 1'b0;
        n_out_status   = ST_OK;
        n_out_last     = 1'b1;
        if (r_dumping) begin
            n_out_valid    = 1'b1;
            n_out_from_ram = 1'b1;
            n_out_last     = (r_dump_addr == '0);
            n_dumping      = (r_dump_addr != '0);
            n_dump_addr    = r_dump_addr - AW'(1);
        end else if (accept) begin
            n_out_valid = 1'b1;
            unique case (action)
                ACT_PUSH: begin
                    if (full) begin
                        n_out_status = ST_OVERFLOW;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
                ACT_POP: begin
                    if (empty) begin
                        n_out_status = ST_EMPTY;
                    end else begin
                        n_count        = count_m1;
                        n_out_from_ram = 1'b1;
                    end
                end
                ACT_PEEK: begin
                    if (empty) begin
                        n_out_status = ST_EMPTY;
                    end else begin
                        n_out_from_ram = 1'b1;
                    end
                end
                ACT_DUMP: begin
                    if (empty) begin
                        n_out_status = ST_EMPTY;
                    end else begin
                        n_out_from_ram = 1'b1;
                        n_out_last     = (count_m1 == '0);
                        n_dumping      = (count_m1 != '0);
                        n_dump_addr    = count_m2[AW-1:0];
                    end
                end
                default: begin
                    n_out_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_dumping   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_count     <= n_count;
            r_dumping   <= n_dumping;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dump_addr    <= n_dump_addr;
        r_out_from_ram <= n_out_from_ram;
        r_out_status   <= n_out_status;
        r_out_last     <= n_out_last;
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_from_ram ? signed'(ram_rdata) : '0;
    assign o_status       = r_out_status;
    assign o_last         = r_out_last;

endmodule
`default_nettype wire

>>> sv/bls_ram.sv
// Single-port-write, single-port-read word memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bls_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire
